### sv/blpi_pkg.sv
package blpi_pkg;

  // Default list depth.
  localparam int unsigned CAPACITY_DEF = 16;

  // Fixed field widths of the command and result channels.
  localparam int unsigned CMD_W     = 2;
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned POS_W     = 4;
  localparam int unsigned STAT_W    = 2;
  localparam int unsigned CNT_OUT_W = 5;

  // Command codes.
  typedef logic [CMD_W-1:0] cmd_t;
  localparam cmd_t CMD_INS_FRONT = 2'd0;
  localparam cmd_t CMD_APPEND    = 2'd1;
  localparam cmd_t CMD_REMOVE    = 2'd2;
  localparam cmd_t CMD_INS_POS   = 2'd3;

  // Result status codes.
  typedef logic [STAT_W-1:0] status_t;
  localparam status_t ST_DONE   = 2'd0;
  localparam status_t ST_FULL   = 2'd1;
  localparam status_t ST_EMPTY  = 2'd2;
  localparam status_t ST_BADPOS = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load;          // capture value, target index and shift index
    logic    rd_last;       // read the last entry and drop it from the count
    logic    shift_rd;      // read the entry below the shift index
    logic    shift_wr;      // write that entry one place up, step the index down
    logic    place;         // write the new value at the target index
    logic    respond;       // launch a result transfer
    status_t resp_status;   // status of that result
    logic    resp_removed;  // result carries the value just read
  } dp_ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_remove;   // incoming command is a remove
    logic empty;       // list holds no entries
    logic bad_pos;     // positional insert at or beyond the count
    logic full;        // list holds CAPACITY entries
    logic need_shift;  // entries remain to move up before the gap is open
  } dp_stat_t;

endpackage

### sv/blpi_ctrl.sv
module blpi_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  blpi_pkg::dp_stat_t stat,
  output blpi_pkg::dp_ctrl_t ctrl,
  output logic              busy
);

  localparam logic [1:0] S_IDLE     = 2'd0;
  localparam logic [1:0] S_SHIFT_RD = 2'd1;
  localparam logic [1:0] S_SHIFT_WR = 2'd2;
  localparam logic [1:0] S_FIN_RM   = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Sequencing of commands into datapath steps.
  always_comb begin
    state_nxt = state_r;
    ctrl      = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          priority if (stat.is_remove && stat.empty) begin
            ctrl.respond     = 1'b1;
            ctrl.resp_status = blpi_pkg::ST_EMPTY;
          end else if (stat.is_remove) begin
            ctrl.rd_last = 1'b1;
            state_nxt    = S_FIN_RM;
          end else if (stat.bad_pos) begin
            ctrl.respond     = 1'b1;
            ctrl.resp_status = blpi_pkg::ST_BADPOS;
          end else if (stat.full) begin
            ctrl.respond     = 1'b1;
            ctrl.resp_status = blpi_pkg::ST_FULL;
          end else begin
            ctrl.load = 1'b1;
            state_nxt = S_SHIFT_RD;
          end
        end
      end
      S_SHIFT_RD: begin
        if (stat.need_shift) begin
          ctrl.shift_rd = 1'b1;
          state_nxt     = S_SHIFT_WR;
        end else begin
          ctrl.place       = 1'b1;
          ctrl.respond     = 1'b1;
          ctrl.resp_status = blpi_pkg::ST_DONE;
          state_nxt        = S_IDLE;
        end
      end
      S_SHIFT_WR: begin
        ctrl.shift_wr = 1'b1;
        state_nxt     = S_SHIFT_RD;
      end
      S_FIN_RM: begin
        ctrl.respond      = 1'b1;
        ctrl.resp_removed = 1'b1;
        ctrl.resp_status  = blpi_pkg::ST_DONE;
        state_nxt         = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

### sv/blpi_dp.sv
module blpi_dp #(
  parameter int unsigned CAPACITY = blpi_pkg::CAPACITY_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [blpi_pkg::CMD_W-1:0]          in_cmd,
  input  logic signed [blpi_pkg::VAL_W-1:0]   in_value,
  input  logic [blpi_pkg::POS_W-1:0]          in_position,
  input  blpi_pkg::dp_ctrl_t                  ctrl,
  output blpi_pkg::dp_stat_t                  stat,
  output logic                                out_strobe,
  output logic [blpi_pkg::STAT_W-1:0]         out_status,
  output logic signed [blpi_pkg::VAL_W-1:0]   out_removed_value,
  output logic [blpi_pkg::CNT_OUT_W-1:0]      out_count
);

  localparam int unsigned AW   = $clog2(CAPACITY);
  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned CMPW = (CW > blpi_pkg::POS_W) ? CW : blpi_pkg::POS_W;

  // Entry store: one write and one registered read per cycle.
  logic [blpi_pkg::VAL_W-1:0] mem [CAPACITY];
  logic [blpi_pkg::VAL_W-1:0] rdata_r;

  logic [CW-1:0]                  count_r;
  logic [CW-1:0]                  count_nxt;
  logic [CW-1:0]                  idx_r;
  logic [CW-1:0]                  tgt_r;
  logic [blpi_pkg::VAL_W-1:0]     value_r;
  logic [CW-1:0]                  tgt_in;

  logic                           rd_en;
  logic [AW-1:0]                  rd_addr;
  logic                           wr_en;
  logic [AW-1:0]                  wr_addr;
  logic [blpi_pkg::VAL_W-1:0]     wr_data;

  logic                           out_strobe_r;
  blpi_pkg::status_t              out_status_r;
  logic [blpi_pkg::VAL_W-1:0]     out_removed_r;
  logic [blpi_pkg::CNT_OUT_W-1:0] out_count_r;

  // Decode of the incoming command against the current fill.
  always_comb begin
    stat.is_remove  = (in_cmd == blpi_pkg::CMD_REMOVE);
    stat.empty      = (count_r == '0);
    stat.bad_pos    = (in_cmd == blpi_pkg::CMD_INS_POS) &&
                      (CMPW'(in_position) >= CMPW'(count_r));
    stat.full       = (count_r == CW'(CAPACITY));
    stat.need_shift = (idx_r > tgt_r);
  end

  // Index at which the new value lands.
  always_comb begin
    unique case (in_cmd)
      blpi_pkg::CMD_INS_FRONT: tgt_in = '0;
      blpi_pkg::CMD_APPEND:    tgt_in = count_r;
      blpi_pkg::CMD_INS_POS:   tgt_in = CW'(in_position);
      default:                 tgt_in = '0;
    endcase
  end

  // Count after this step.
  always_comb begin
    count_nxt = count_r;
    if (ctrl.rd_last) begin
      count_nxt = count_r - 1'b1;
    end else if (ctrl.place) begin
      count_nxt = count_r + 1'b1;
    end
  end

  // Memory port selection.
  assign rd_en   = ctrl.rd_last | ctrl.shift_rd;
  assign rd_addr = ctrl.rd_last ? AW'(count_r - 1'b1) : AW'(idx_r - 1'b1);
  assign wr_en   = ctrl.shift_wr | ctrl.place;
  assign wr_addr = ctrl.shift_wr ? idx_r[AW-1:0] : tgt_r[AW-1:0];
  assign wr_data = ctrl.shift_wr ? rdata_r : value_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  // Fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Insert context: value, target and the index of the gap being opened.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      value_r <= in_value;
      tgt_r   <= tgt_in;
      idx_r   <= count_r;
    end else if (ctrl.shift_wr) begin
      idx_r   <= idx_r - 1'b1;
    end
  end

  // Result register; the strobe marks a one-cycle transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= ctrl.respond;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.respond) begin
      out_status_r  <= ctrl.resp_status;
      out_removed_r <= ctrl.resp_removed ? rdata_r : '0;
      out_count_r   <= blpi_pkg::CNT_OUT_W'(count_nxt);
    end
  end

  assign out_strobe        = out_strobe_r;
  assign out_status        = out_status_r;
  assign out_removed_value = out_removed_r;
  assign out_count         = out_count_r;

endmodule

### sv/bounded_list_with_positional_insert.sv
// Channel   | Ports                                        | Transfer
// ----------+----------------------------------------------+---------------------------
// command   | start, busy, in_cmd, in_value, in_position   | edge with start & !busy
// result    | out_strobe, out_status, out_removed_value,   | every cycle out_strobe is
//           | out_count                                    | high, cannot be held off
//
// Errors (full, empty, bad position) give their result in the cycle after the transfer.
// Remove last reads the last entry from memory, then returns it as the result.
// An insert moves one entry of the entry memory up per read/write pair until the gap
// at the target index is open, then writes the new value there.
// Reset clears the count and the control; the entry memory is not cleared.
// busy stays high from an insert or remove transfer to the cycle its result appears.
module bounded_list_with_positional_insert #(
  parameter int unsigned CAPACITY = blpi_pkg::CAPACITY_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [blpi_pkg::CMD_W-1:0]        in_cmd,
  input  logic signed [blpi_pkg::VAL_W-1:0] in_value,
  input  logic [blpi_pkg::POS_W-1:0]        in_position,
  output logic                              out_strobe,
  output logic [blpi_pkg::STAT_W-1:0]       out_status,
  output logic signed [blpi_pkg::VAL_W-1:0] out_removed_value,
  output logic [blpi_pkg::CNT_OUT_W-1:0]    out_count
);

  blpi_pkg::dp_ctrl_t ctrl;
  blpi_pkg::dp_stat_t stat;

  // Command sequencer.
  blpi_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .ctrl  (ctrl),
    .busy  (busy)
  );

  // Entry store, count and result register.
  blpi_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_cmd            (in_cmd),
    .in_value          (in_value),
    .in_position       (in_position),
    .ctrl              (ctrl),
    .stat              (stat),
    .out_strobe        (out_strobe),
    .out_status        (out_status),
    .out_removed_value (out_removed_value),
    .out_count         (out_count)
  );

endmodule

### sv/blpi_checker.sv
module blpi_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              start,
  input logic                              busy,
  input logic [blpi_pkg::STAT_W-1:0]       out_status,
  input logic signed [blpi_pkg::VAL_W-1:0] out_removed_value,
  input logic [blpi_pkg::CNT_OUT_W-1:0]    out_count,
  input logic                              out_strobe
);

  // A result only follows a command transfer or work in progress.
  a_strobe_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start || busy))
    else $error("result without a command");

  // Busy is only entered by a command transfer.
  a_busy_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a command transfer");

  // Leaving busy always delivers the result in the same cycle.
  a_busy_fall: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_strobe)
    else $error("busy dropped without a result");

  // Failed commands return no removed value.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_status != blpi_pkg::ST_DONE)) |-> (out_removed_value == '0))
    else $error("error result carries a removed value");

  // An empty-list error reports an empty list.
  a_empty_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_status == blpi_pkg::ST_EMPTY)) |-> (out_count == '0))
    else $error("empty status with nonzero count");

endmodule

bind bounded_list_with_positional_insert blpi_checker u_blpi_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .out_status        (out_status),
  .out_removed_value (out_removed_value),
  .out_count         (out_count),
  .out_strobe        (out_strobe)
);
